// File: design/ssca_pkg.sv
// ----------------------------------------------------------------------------
// ssca_pkg
// Shared constants and types for the shadow slot cache allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssca_pkg;

   localparam int SLOTS_DEFAULT = 8;

   localparam int MAC_OP_W = 33;
   localparam int ACC_W    = 2 * MAC_OP_W;

   localparam logic [3:0]  SLOT_COUNT_RESET       = 4'd8;
   localparam logic [15:0] RADIUS_SCALE_RESET     = 16'd256;
   localparam logic [15:0] RADIUS_TOLERANCE_RESET = 16'd16;
   localparam logic [15:0] ANGLE_THRESHOLD_RESET  = 16'd65470;

   localparam logic [1:0] CSR_SLOT_COUNT       = 2'd0;
   localparam logic [1:0] CSR_RADIUS_SCALE     = 2'd1;
   localparam logic [1:0] CSR_RADIUS_TOLERANCE = 2'd2;
   localparam logic [1:0] CSR_ANGLE_THRESHOLD  = 2'd3;

   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_AGING   = 1'b1;

   typedef struct packed {
      logic enable;
      logic accum;
   } mac_ctrl_type;

endpackage

`default_nettype wire

// File: design/shadow_slot_cache_allocator_unit.sv
// ----------------------------------------------------------------------------
// shadow_slot_cache_allocator_unit
// Shadow slot table with owner/radius/light-direction cache matching and
// frame aging, scanned slot by slot around one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+----------------------
//  request  | start, busy, req_*                      | start & !busy
//  result   | rsp_valid, rsp_*                        | one-cycle strobe
//  config   | csr_valid, csr_ready, csr_index/data    | valid & ready
//
//  Aging item: handled in S_IDLE without raising busy, result strobe on the
//  following cycle. Request item: busy while the scaled radius and light
//  norm are formed, then each of N slots is read and checked, with an angle
//  test on an owner and radius match; a cache hit ends the scan. The steps
//  are serialized by the single multiply-accumulate unit and one-port slot read.
//  Reset clears control state and marks and loads the configuration reset values at once.
//  The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module shadow_slot_cache_allocator_unit import ssca_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic               req_kind,
   input  wire logic [15:0]        req_owner_id,
   input  wire logic [15:0]        req_radius,
   input  wire logic signed [15:0] req_light_x,
   input  wire logic signed [15:0] req_light_y,
   input  wire logic signed [15:0] req_light_z,
   output      logic               rsp_valid,
   output      logic [2:0]         rsp_slot_index,
   output      logic               rsp_cache_hit,
   output      logic               rsp_needs_render,
   output      logic               rsp_overflow,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SCALE, S_NX, S_NY, S_NZ, S_NORM, S_ISSUE, S_EVAL,
      S_DY, S_DZ, S_SQ, S_PN, S_PL, S_PH, S_CMP, S_DONE
   } state_type;

   typedef struct packed {
      logic [15:0]        owner;
      logic signed [15:0] lx;
      logic signed [15:0] ly;
      logic signed [15:0] lz;
      logic [23:0]        radius;
      logic [31:0]        norm;
   } slot_entry_type;

   state_type state_ff, state_in;

   logic [3:0]  slot_count_ff, slot_count_in;
   logic [15:0] radius_scale_ff, radius_scale_in;
   logic [15:0] radius_tol_ff, radius_tol_in;
   logic [15:0] angle_thr_ff, angle_thr_in;

   logic [SLOTS-1:0] slot_occupied_ff, slot_occupied_in;
   logic [SLOTS-1:0] slot_in_use_ff, slot_in_use_in;

   logic [15:0]        owner_ff, owner_in;
   logic [15:0]        radius_ff, radius_in;
   logic signed [15:0] lx_ff, lx_in;
   logic signed [15:0] ly_ff, ly_in;
   logic signed [15:0] lz_ff, lz_in;
   logic [23:0]        sr_ff, sr_in;
   logic [31:0]        nb_ff, nb_in;
   logic [63:0]        sq_ff, sq_in;
   logic [31:0]        phi_ff, phi_in;
   logic [47:0]        rlo_ff, rlo_in;

   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [1:0]       level_ff, level_in;
   logic             found_ff, found_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_slot_index_ff, rsp_slot_index_in;
   logic       rsp_hit_ff, rsp_hit_in;
   logic       rsp_render_ff, rsp_render_in;
   logic       rsp_overflow_ff, rsp_overflow_in;

   slot_entry_type slot_mem [SLOTS];
   slot_entry_type rd_ff;
   slot_entry_type wr_entry;
   logic           rd_en;
   logic           wr_en;

   mac_ctrl_type               mac_ctrl;
   logic signed [MAC_OP_W-1:0] mac_a;
   logic signed [MAC_OP_W-1:0] mac_b;
   logic signed [ACC_W-1:0]    acc;

   logic [7:0]         count_ext;
   logic [CNT_W-1:0]   n_now;
   logic [IDX_W-1:0]   scan_idx;
   logic               same_owner;
   logic [23:0]        radius_diff;
   logic signed [32:0] dot_sum;
   logic [31:0]        dot_mag;
   logic [79:0]        lhs;
   logic [79:0]        rhs;
   logic [7:0]         idx_wide;
   logic               accept;

   ssca_mac_unit u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (acc)
   );

   assign accept    = start && (state_ff == S_IDLE);
   assign count_ext = 8'(slot_count_ff);
   assign n_now     = (count_ext > 8'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(slot_count_ff);
   assign scan_idx  = scan_ff[IDX_W-1:0];

   assign same_owner  = slot_occupied_ff[scan_idx] && (rd_ff.owner == owner_ff);
   assign radius_diff = (rd_ff.radius > sr_ff) ? (rd_ff.radius - sr_ff)
                                               : (sr_ff - rd_ff.radius);
   assign dot_sum = acc[32:0];
   assign dot_mag = dot_sum[32] ? 32'(-dot_sum) : dot_sum[31:0];
   assign lhs     = {sq_ff, 16'd0};
   assign rhs     = {acc[47:0], 32'd0} + {32'd0, rlo_ff};
   assign idx_wide = 8'(idx_ff);

   assign rd_en = (state_ff == S_ISSUE) && (scan_ff != n_ff);
   assign wr_en = (state_ff == S_DONE) && found_ff && (level_ff != 2'd3);
   assign wr_entry = '{owner: owner_ff, lx: lx_ff, ly: ly_ff, lz: lz_ff,
                       radius: sr_ff, norm: nb_ff};

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= slot_mem[scan_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[idx_ff] <= wr_entry;
      end
   end

   always_comb begin
      state_in         = state_ff;
      slot_count_in    = slot_count_ff;
      radius_scale_in  = radius_scale_ff;
      radius_tol_in    = radius_tol_ff;
      angle_thr_in     = angle_thr_ff;
      slot_occupied_in = slot_occupied_ff;
      slot_in_use_in   = slot_in_use_ff;
      owner_in         = owner_ff;
      radius_in        = radius_ff;
      lx_in            = lx_ff;
      ly_in            = ly_ff;
      lz_in            = lz_ff;
      sr_in            = sr_ff;
      nb_in            = nb_ff;
      sq_in            = sq_ff;
      phi_in           = phi_ff;
      rlo_in           = rlo_ff;
      n_in             = n_ff;
      scan_in          = scan_ff;
      idx_in           = idx_ff;
      level_in         = level_ff;
      found_in         = found_ff;
      rsp_valid_in      = 1'b0;
      rsp_slot_index_in = rsp_slot_index_ff;
      rsp_hit_in        = rsp_hit_ff;
      rsp_render_in     = rsp_render_ff;
      rsp_overflow_in   = rsp_overflow_ff;
      mac_ctrl = '{enable: 1'b0, accum: 1'b0};
      mac_a    = '0;
      mac_b    = '0;

      if (csr_valid) begin
         case (csr_index)
            CSR_SLOT_COUNT:       slot_count_in   = csr_data[3:0];
            CSR_RADIUS_SCALE:     radius_scale_in = csr_data;
            CSR_RADIUS_TOLERANCE: radius_tol_in   = csr_data;
            CSR_ANGLE_THRESHOLD:  angle_thr_in    = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               n_in     = n_now;
               owner_in = req_owner_id;
               radius_in = req_radius;
               lx_in    = req_light_x;
               ly_in    = req_light_y;
               lz_in    = req_light_z;
               scan_in  = '0;
               idx_in   = '0;
               level_in = 2'd0;
               found_in = 1'b0;
               if (req_kind == KIND_AGING) begin
                  for (int i = 0; i < SLOTS; i++) begin
                     if ((CNT_W'(i) < n_now) && slot_occupied_ff[i]) begin
                        if (slot_in_use_ff[i]) begin
                           slot_in_use_in[i] = 1'b0;
                        end else begin
                           slot_occupied_in[i] = 1'b0;
                        end
                     end
                  end
                  rsp_valid_in      = 1'b1;
                  rsp_slot_index_in = 3'd0;
                  rsp_hit_in        = 1'b0;
                  rsp_render_in     = 1'b0;
                  rsp_overflow_in   = 1'b0;
               end else begin
                  state_in = S_SCALE;
               end
            end
         end
         S_SCALE: begin
            mac_ctrl = '{enable: 1'b1, accum: 1'b0};
            mac_a    = signed'({17'd0, radius_ff});
            mac_b    = signed'({17'd0, radius_scale_ff});
            state_in = S_NX;
         end
         S_NX: begin
            sr_in    = acc[31:8];
            mac_ctrl = '{enable: 1'b1, accum: 1'b0};
            mac_a    = 33'(lx_ff);
            mac_b    = 33'(lx_ff);
            state_in = S_NY;
         end
         S_NY: begin
            mac_ctrl = '{enable: 1'b1, accum: 1'b1};
            mac_a    = 33'(ly_ff);
            mac_b    = 33'(ly_ff);
            state_in = S_NZ;
         end
         S_NZ: begin
            mac_ctrl = '{enable: 1'b1, accum: 1'b1};
            mac_a    = 33'(lz_ff);
            mac_b    = 33'(lz_ff);
            state_in = S_NORM;
         end
         S_NORM: begin
            nb_in    = acc[31:0];
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            state_in = (scan_ff == n_ff) ? S_DONE : S_EVAL;
         end
         S_EVAL: begin
            if ((level_ff == 2'd0) && !slot_in_use_ff[scan_idx]) begin
               idx_in   = scan_idx;
               found_in = 1'b1;
               level_in = slot_occupied_ff[scan_idx] ? 2'd0 : 2'd1;
            end
            if ((level_in <= 2'd1) && same_owner && !slot_in_use_ff[scan_idx]) begin
               idx_in   = scan_idx;
               found_in = 1'b1;
               level_in = 2'd2;
            end
            if (same_owner && (radius_diff < {8'd0, radius_tol_ff})) begin
               mac_ctrl = '{enable: 1'b1, accum: 1'b0};
               mac_a    = 33'(lx_ff);
               mac_b    = 33'(rd_ff.lx);
               state_in = S_DY;
            end else begin
               scan_in  = scan_ff + CNT_W'(1);
               state_in = S_ISSUE;
            end
         end
         S_DY: begin
            mac_ctrl = '{enable: 1'b1, accum: 1'b1};
            mac_a    = 33'(ly_ff);
            mac_b    = 33'(rd_ff.ly);
            state_in = S_DZ;
         end
         S_DZ: begin
            mac_ctrl = '{enable: 1'b1, accum: 1'b1};
            mac_a    = 33'(lz_ff);
            mac_b    = 33'(rd_ff.lz);
            state_in = S_SQ;
         end
         S_SQ: begin
            mac_ctrl = '{enable: 1'b1, accum: 1'b0};
            mac_a    = signed'({1'b0, dot_mag});
            mac_b    = signed'({1'b0, dot_mag});
            state_in = S_PN;
         end
         S_PN: begin
            sq_in    = acc[63:0];
            mac_ctrl = '{enable: 1'b1, accum: 1'b0};
            mac_a    = signed'({1'b0, rd_ff.norm});
            mac_b    = signed'({1'b0, nb_ff});
            state_in = S_PL;
         end
         S_PL: begin
            phi_in   = acc[63:32];
            mac_ctrl = '{enable: 1'b1, accum: 1'b0};
            mac_a    = signed'({1'b0, acc[31:0]});
            mac_b    = signed'({17'd0, angle_thr_ff});
            state_in = S_PH;
         end
         S_PH: begin
            rlo_in   = acc[47:0];
            mac_ctrl = '{enable: 1'b1, accum: 1'b0};
            mac_a    = signed'({1'b0, phi_ff});
            mac_b    = signed'({17'd0, angle_thr_ff});
            state_in = S_CMP;
         end
         S_CMP: begin
            if (lhs >= rhs) begin
               idx_in   = scan_idx;
               found_in = 1'b1;
               level_in = 2'd3;
               state_in = S_DONE;
            end else begin
               scan_in  = scan_ff + CNT_W'(1);
               state_in = S_ISSUE;
            end
         end
         S_DONE: begin
            rsp_valid_in      = 1'b1;
            rsp_slot_index_in = 3'd0;
            rsp_hit_in        = 1'b0;
            rsp_render_in     = 1'b0;
            rsp_overflow_in   = 1'b0;
            if (!found_ff) begin
               rsp_overflow_in = 1'b1;
            end else begin
               rsp_slot_index_in      = idx_wide[2:0];
               slot_in_use_in[idx_ff] = 1'b1;
               if (level_ff == 2'd3) begin
                  rsp_hit_in = 1'b1;
               end else begin
                  slot_occupied_in[idx_ff] = 1'b1;
                  rsp_render_in            = 1'b1;
               end
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         slot_count_ff    <= SLOT_COUNT_RESET;
         radius_scale_ff  <= RADIUS_SCALE_RESET;
         radius_tol_ff    <= RADIUS_TOLERANCE_RESET;
         angle_thr_ff     <= ANGLE_THRESHOLD_RESET;
         slot_occupied_ff <= '0;
         slot_in_use_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         slot_count_ff    <= slot_count_in;
         radius_scale_ff  <= radius_scale_in;
         radius_tol_ff    <= radius_tol_in;
         angle_thr_ff     <= angle_thr_in;
         slot_occupied_ff <= slot_occupied_in;
         slot_in_use_ff   <= slot_in_use_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      owner_ff          <= owner_in;
      radius_ff         <= radius_in;
      lx_ff             <= lx_in;
      ly_ff             <= ly_in;
      lz_ff             <= lz_in;
      sr_ff             <= sr_in;
      nb_ff             <= nb_in;
      sq_ff             <= sq_in;
      phi_ff            <= phi_in;
      rlo_ff            <= rlo_in;
      n_ff              <= n_in;
      scan_ff           <= scan_in;
      idx_ff            <= idx_in;
      level_ff          <= level_in;
      found_ff          <= found_in;
      rsp_slot_index_ff <= rsp_slot_index_in;
      rsp_hit_ff        <= rsp_hit_in;
      rsp_render_ff     <= rsp_render_in;
      rsp_overflow_ff   <= rsp_overflow_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_index   = rsp_slot_index_ff;
   assign rsp_cache_hit    = rsp_hit_ff;
   assign rsp_needs_render = rsp_render_ff;
   assign rsp_overflow     = rsp_overflow_ff;

`ifndef NO_ASSERTIONS
   // an in-use slot is always occupied
   a_in_use_occupied: assert property (@(posedge clock) disable iff (reset)
      (slot_in_use_ff & ~slot_occupied_ff) == '0)
      else $error("in-use slot not occupied");

   // at most one outcome flag per result
   a_outcome_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_cache_hit, rsp_needs_render, rsp_overflow}))
      else $error("conflicting result flags");

   // a request item keeps the block busy
   a_request_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_REQUEST)) |=> busy)
      else $error("request item did not start a scan");

   // overflow results carry slot zero
   a_overflow_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (rsp_slot_index == 3'd0))
      else $error("overflow with non-zero slot");
`endif

endmodule

`default_nettype wire

// File: design/ssca_mac_unit.sv
// ----------------------------------------------------------------------------
// ssca_mac_unit
// Shared signed multiply-accumulate unit with a registered accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module ssca_mac_unit import ssca_pkg::*;
(
   input  wire logic                       clock,
   input  wire mac_ctrl_type               ctrl,
   input  wire logic signed [MAC_OP_W-1:0] op_a,
   input  wire logic signed [MAC_OP_W-1:0] op_b,
   output      logic signed [ACC_W-1:0]    acc
);

   logic signed [ACC_W-1:0] product;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;

   assign product = op_a * op_b;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.enable) begin
         acc_in = (ctrl.accum ? acc_ff : '0) + product;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire
